/* hdl/dscu_pkg.sv */
// Shared constants and types for the DER signature encoding check.
package dscu_pkg;

  localparam int MaxSigBytes = 73;
  localparam int PosCapInt   = (MaxSigBytes + 1 > 127) ? 127 : MaxSigBytes + 1;
  localparam int PosW        = 7;

  localparam logic [PosW-1:0] PosCap     = PosW'(PosCapInt);
  localparam logic [PosW:0]   MaxSig     = (PosW + 1)'(MaxSigBytes);
  localparam logic [PosW:0]   MinSig     = (PosW + 1)'(9);
  localparam logic [7:0]      SeqTag     = 8'h30;
  localparam logic [7:0]      IntTag     = 8'h02;
  localparam logic [7:0]      MaxIntLen  = 8'd33;
  localparam int              SignBit    = 7;

  typedef struct packed {
    logic       header_tag_ok;
    logic [7:0] declared_length;
    logic       r_tag_ok;
    logic [7:0] r_length;
    logic [7:0] r_head0;
    logic [7:0] r_head1;
    logic       s_tag_ok;
    logic [7:0] s_length;
    logic [7:0] s_head0;
    logic [7:0] s_head1;
  } dscu_fields_t;

  typedef struct packed {
    logic            in_range;
    logic [PosW:0]   total;
  } dscu_status_t;

endpackage

/* hdl/dscu_capture.sv */
// Position counter and field capture registers for one signature.
module dscu_capture (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            sig_byte,
  input  logic                  last_byte,
  output dscu_pkg::dscu_fields_t fields_next,
  output dscu_pkg::dscu_status_t status
);

  logic [dscu_pkg::PosW-1:0] byte_position;
  logic [dscu_pkg::PosW-1:0] byte_position_next;
  dscu_pkg::dscu_fields_t    fields;
  logic [8:0]                pos9;
  logic [8:0]                rl9;
  logic                      in_range;

  assign pos9     = {2'b00, byte_position};
  assign rl9      = {1'b0, fields.r_length};
  assign in_range = byte_position < dscu_pkg::PosCap;

  always_comb begin
    fields_next = fields;
    if (in_range) begin
      if (pos9 == 9'd0) fields_next.header_tag_ok = (sig_byte == dscu_pkg::SeqTag);
      if (pos9 == 9'd1) fields_next.declared_length = sig_byte;
      if (pos9 == 9'd2) fields_next.r_tag_ok = (sig_byte == dscu_pkg::IntTag);
      if (pos9 == 9'd3) fields_next.r_length = sig_byte;
      if (pos9 == 9'd4) fields_next.r_head0 = sig_byte;
      if (pos9 == 9'd5) fields_next.r_head1 = sig_byte;
      if (pos9 > 9'd3) begin
        if (pos9 == rl9 + 9'd4) fields_next.s_tag_ok = (sig_byte == dscu_pkg::IntTag);
        if (pos9 == rl9 + 9'd5) fields_next.s_length = sig_byte;
        if (pos9 == rl9 + 9'd6) fields_next.s_head0 = sig_byte;
        if (pos9 == rl9 + 9'd7) fields_next.s_head1 = sig_byte;
      end
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    if (in_range) byte_position_next = byte_position + 1'b1;
  end

  assign status.in_range = in_range;
  assign status.total    = {1'b0, byte_position} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      fields        <= '0;
    end else if (advance) begin
      if (last_byte) begin
        byte_position <= '0;
        fields        <= '0;
      end else begin
        byte_position <= byte_position_next;
        fields        <= fields_next;
      end
    end
  end

  a_pos_capped: assert property (@(posedge clk) disable iff (rst)
    byte_position <= dscu_pkg::PosCap)
    else $error("byte position above cap");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && last_byte |=> byte_position == '0 && fields == '0)
    else $error("state not cleared after last byte");

endmodule

/* hdl/dscu_verdict.sv */
// Strict DER rule evaluation over the captured fields.
module dscu_verdict (
  input  dscu_pkg::dscu_fields_t fields,
  input  dscu_pkg::dscu_status_t status,
  output logic                   ok
);

  logic [dscu_pkg::PosW:0] n;
  logic [9:0]              der;
  logic [9:0]              n10;
  logic [8:0]              r_end;
  logic                    len_ok;
  logic                    decl_ok;
  logic                    r_ok;
  logic                    s_ok;
  logic                    der_ok;
  logic                    sign_ok;
  logic                    pad_ok;

  assign n     = status.total;
  assign n10   = 10'(n);
  assign der   = 10'(fields.r_length) + 10'(fields.s_length) + 10'd6;
  assign r_end = 9'(fields.r_length) + 9'd5;

  assign len_ok  = status.in_range && n >= dscu_pkg::MinSig && n <= dscu_pkg::MaxSig;
  assign decl_ok = fields.header_tag_ok &&
                   (fields.declared_length == 8'(n - 2'd2) ||
                    fields.declared_length == 8'(n - 2'd3));
  assign r_ok    = fields.r_tag_ok && fields.r_length != 8'd0 &&
                   fields.r_length <= dscu_pkg::MaxIntLen && r_end < 9'(n);
  assign s_ok    = fields.s_tag_ok && fields.s_length != 8'd0 &&
                   fields.s_length <= dscu_pkg::MaxIntLen;
  assign der_ok  = der == n10 || der == n10 - 10'd1;
  assign sign_ok = !fields.r_head0[dscu_pkg::SignBit] && !fields.s_head0[dscu_pkg::SignBit];
  assign pad_ok  = !(fields.r_length > 8'd1 && fields.r_head0 == 8'd0 &&
                     !fields.r_head1[dscu_pkg::SignBit]) &&
                   !(fields.s_length > 8'd1 && fields.s_head0 == 8'd0 &&
                     !fields.s_head1[dscu_pkg::SignBit]);

  assign ok = len_ok && decl_ok && r_ok && s_ok && der_ok && sign_ok && pad_ok;

endmodule

/* hdl/der_signature_encoding_check_unit.sv */
// Streaming strict DER check of one ECDSA signature, one byte per transfer.
// Accepts one byte every clock cycle unless a last byte waits; the verdict for a
// signature reaches the result port through one input register and one result
// register. Only the last byte yields a result. A last byte waits in the input
// register only while an earlier verdict is still held unaccepted.
module der_signature_encoding_check_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] sig_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       encoding_valid
);

  logic                   byte_valid;
  logic [7:0]             byte_hold;
  logic                   last_hold;
  logic                   advance;
  logic                   ok;
  dscu_pkg::dscu_fields_t fields_next;
  dscu_pkg::dscu_status_t status;

  assign advance  = byte_valid && (!last_hold || !out_valid || out_ready);
  assign in_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_hold <= sig_byte;
      last_hold <= last_byte;
    end
  end

  dscu_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .sig_byte    (byte_hold),
    .last_byte   (last_hold),
    .fields_next (fields_next),
    .status      (status)
  );

  dscu_verdict u_verdict (
    .fields (fields_next),
    .status (status),
    .ok     (ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_hold) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_hold) encoding_valid <= ok;
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && last_hold |=> out_valid)
    else $error("last byte produced no result");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !byte_valid |-> in_ready)
    else $error("empty input register refused a byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(advance && last_hold))
    else $error("pending result overwritten");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench: strict DER signature byte stream against a local verdict predictor.
module testbench;

  localparam int MinSigLen   = 9;
  localparam int CycleLimit  = 600000;
  localparam int DrainCycles = 12;
  localparam int MaxPrinted  = 40;
  localparam logic [7:0] SeqTag = dscu_pkg::SeqTag;
  localparam logic [7:0] IntTag = dscu_pkg::IntTag;

  typedef enum logic [1:0] {WANT_FAIL, WANT_PASS, WANT_MODEL} want_e;

  typedef struct packed {
    logic [7:0]        hdr;
    logic signed [7:0] decl_adj;
    logic [7:0]        rtag;
    logic [7:0]        rlen;
    logic [7:0]        r0;
    logic [7:0]        r1;
    logic [7:0]        stag;
    logic [7:0]        slen;
    logic [7:0]        s0;
    logic [7:0]        s1;
    logic              hash;
    logic [7:0]        pad;
    want_e             want;
  } sig_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] sig_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_ready;
  logic       encoding_valid;

  logic [6:0]             trk_pos;
  dscu_pkg::dscu_fields_t trk;
  logic                   verdict_q[$];
  logic [7:0]             sig_bytes[$];
  sig_row_t               dir_rows[$];
  int unsigned            mismatches = 0;
  int unsigned            cycles = 0;
  int unsigned            stall_left = 0;
  int unsigned            bytes_sent = 0;
  int unsigned            rand_sigs = 0;
  bit                     quiet = 1'b0;

  der_signature_encoding_check_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sig_byte       (sig_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .encoding_valid (encoding_valid)
  );

  always #5 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic sig_row_t row(input logic [7:0] hdr, input logic [7:0] rtag,
                                   input int rlen, input logic [7:0] r0,
                                   input logic [7:0] r1, input logic [7:0] stag,
                                   input int slen, input logic [7:0] s0,
                                   input logic [7:0] s1, input int hash, input int adj,
                                   input int pad, input want_e want);
    sig_row_t rw;
    rw.hdr      = hdr;
    rw.decl_adj = 8'(adj);
    rw.rtag     = rtag;
    rw.rlen     = 8'(rlen);
    rw.r0       = r0;
    rw.r1       = r1;
    rw.stag     = stag;
    rw.slen     = 8'(slen);
    rw.s0       = s0;
    rw.s1       = s1;
    rw.hash     = 1'(hash);
    rw.pad      = 8'(pad);
    rw.want     = want;
    return rw;
  endfunction

  task automatic add_row(input sig_row_t rw);
    dir_rows.insert(dir_rows.size(), rw);
  endtask

  task automatic put_byte(input logic [7:0] b);
    sig_bytes.insert(sig_bytes.size(), b);
  endtask

  task automatic note_mismatch(input string what);
    if (mismatches < MaxPrinted) $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  function automatic bit sig_passes(input int unsigned n);
    int unsigned rl, sl, der;
    rl  = trk.r_length;
    sl  = trk.s_length;
    der = 6 + rl + sl;
    if (n < MinSigLen || n > dscu_pkg::MaxSigBytes) return 1'b0;
    if (!trk.header_tag_ok || !trk.r_tag_ok || !trk.s_tag_ok) return 1'b0;
    if (trk.declared_length != n - 2 && trk.declared_length != n - 3) return 1'b0;
    if (rl == 0 || rl > dscu_pkg::MaxIntLen || 5 + rl >= n) return 1'b0;
    if (sl == 0 || sl > dscu_pkg::MaxIntLen) return 1'b0;
    if (der != n && der != n - 1) return 1'b0;
    if (trk.r_head0[dscu_pkg::SignBit] || trk.s_head0[dscu_pkg::SignBit]) return 1'b0;
    if (rl > 1 && trk.r_head0 == 8'h00 && !trk.r_head1[dscu_pkg::SignBit]) return 1'b0;
    if (sl > 1 && trk.s_head0 == 8'h00 && !trk.s_head1[dscu_pkg::SignBit]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic last, input want_e want);
    int unsigned p, rl;
    bit ok;
    p  = trk_pos;
    rl = trk.r_length;
    if (p < dscu_pkg::PosCapInt) begin
      if (p == 0) trk.header_tag_ok = (b == SeqTag);
      if (p == 1) trk.declared_length = b;
      if (p == 2) trk.r_tag_ok = (b == IntTag);
      if (p == 3) trk.r_length = b;
      if (p == 4) trk.r_head0 = b;
      if (p == 5) trk.r_head1 = b;
      if (p > 3) begin
        if (p == 4 + rl) trk.s_tag_ok = (b == IntTag);
        if (p == 5 + rl) trk.s_length = b;
        if (p == 6 + rl) trk.s_head0 = b;
        if (p == 7 + rl) trk.s_head1 = b;
      end
    end
    if (!last) begin
      if (p < dscu_pkg::PosCapInt) trk_pos = trk_pos + 1'b1;
    end else begin
      ok = (p < dscu_pkg::PosCapInt) && sig_passes(p + 1);
      verdict_q.insert(verdict_q.size(), want == WANT_MODEL ? ok : want == WANT_PASS);
      trk     = '0;
      trk_pos = '0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input want_e want);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sig_byte  <= b;
    last_byte <= last;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    track_byte(b, last, want);
  endtask

  task automatic send_sig(input want_e want);
    foreach (sig_bytes[i]) send_byte(sig_bytes[i], i == sig_bytes.size() - 1, want);
  endtask

  task automatic form_sig(input sig_row_t rw);
    sig_bytes.delete();
    put_byte(rw.hdr);
    put_byte(8'(4 + rw.rlen + rw.slen + rw.decl_adj));
    put_byte(rw.rtag);
    put_byte(rw.rlen);
    for (int i = 0; i < rw.rlen; i++)
      put_byte(i == 0 ? rw.r0 : i == 1 ? rw.r1 : 8'($urandom));
    put_byte(rw.stag);
    put_byte(rw.slen);
    for (int i = 0; i < rw.slen; i++)
      put_byte(i == 0 ? rw.s0 : i == 1 ? rw.s1 : 8'($urandom));
    if (rw.hash) put_byte(8'($urandom_range(1, 255)));
    repeat (rw.pad) put_byte(8'($urandom));
  endtask

  task automatic pick_head(output logic [7:0] h0, output logic [7:0] h1);
    int unsigned r;
    r  = $urandom_range(0, 9);
    h1 = 8'($urandom);
    if (r < 3) h0 = 8'h00;
    else if (r < 8) h0 = 8'($urandom_range(1, 127));
    else h0 = 8'($urandom);
  endtask

  function automatic logic [7:0] pick_int_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'($urandom_range(1, 4));
    if (r < 7) return 8'($urandom_range(31, 33));
    return 8'($urandom_range(1, 33));
  endfunction

  task automatic make_random_sig();
    sig_row_t    rw;
    logic [7:0]  h0, h1;
    int unsigned len, k;
    if ($urandom_range(0, 99) < 15) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(74, 160) : $urandom_range(1, 80);
      sig_bytes.delete();
      repeat (len) put_byte(8'($urandom));
      if ($urandom_range(0, 1) == 1) sig_bytes[0] = SeqTag;
    end else begin
      rw = row(SeqTag, IntTag, int'(pick_int_len()), 8'h00, 8'h00, IntTag,
               int'(pick_int_len()), 8'h00, 8'h00, int'($urandom_range(0, 1)), 0, 0,
               WANT_MODEL);
      pick_head(h0, h1);
      rw.r0 = h0;
      rw.r1 = h1;
      pick_head(h0, h1);
      rw.s0 = h0;
      rw.s1 = h1;
      if ($urandom_range(0, 99) < 30) begin
        case ($urandom_range(0, 6))
          0: rw.hdr = 8'($urandom);
          1: rw.rtag = 8'($urandom);
          2: rw.stag = 8'($urandom);
          3: rw.decl_adj = 8'($urandom_range(0, 4) - 2);
          4: rw.rlen = 8'($urandom_range(0, 40));
          5: rw.slen = 8'($urandom_range(0, 40));
          default: rw.pad = 8'($urandom_range(1, 3));
        endcase
      end
      form_sig(rw);
      if ($urandom_range(0, 99) < 10) begin
        k = $urandom_range(0, sig_bytes.size() - 1);
        if ($urandom_range(0, 1) == 1) sig_bytes[k] = 8'($urandom);
        else while (sig_bytes.size() > k + 1) void'(sig_bytes.pop_back());
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= gap_len();
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        note_mismatch($sformatf("verdict %0b with none pending", encoding_valid));
      end else begin
        if (encoding_valid !== verdict_q[0])
          note_mismatch($sformatf("encoding_valid %0b, expected %0b", encoding_valid,
                                  verdict_q[0]));
        void'(verdict_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    sig_byte  = 8'h00;
    last_byte = 1'b0;
    out_ready = 1'b0;
    trk       = '0;
    trk_pos   = '0;

    add_row(row(SeqTag, IntTag, 1, 8'h01, 8'h00, IntTag, 1, 8'h01, 8'h00, 1, 0, 0,
                WANT_PASS));
    add_row(row(SeqTag, IntTag, 1, 8'h01, 8'h00, IntTag, 1, 8'h01, 8'h00, 0, 0, 0,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 33, 8'h00, 8'h80, IntTag, 33, 8'h00, 8'hff, 1, 0, 0,
                WANT_PASS));
    add_row(row(SeqTag, IntTag, 33, 8'h00, 8'h80, IntTag, 33, 8'h00, 8'hff, 1, 0, 1,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 33, 8'h00, 8'h80, IntTag, 33, 8'h00, 8'hff, 1, 0, 60,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 32, 8'h7f, 8'hff, IntTag, 32, 8'h01, 8'h00, 1, 0, 0,
                WANT_PASS));
    add_row(row(8'hff, IntTag, 32, 8'h7f, 8'hff, IntTag, 32, 8'h01, 8'h00, 1, 0, 0,
                WANT_FAIL));
    add_row(row(8'h00, 8'h00, 0, 8'h00, 8'h00, 8'h00, 0, 8'h00, 8'h00, 0, 0, 0,
                WANT_FAIL));
    add_row(row(SeqTag, 8'h03, 2, 8'h11, 8'h22, IntTag, 2, 8'h33, 8'h44, 1, 0, 0,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 2, 8'h11, 8'h22, 8'h00, 2, 8'h33, 8'h44, 1, 0, 0,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 1, 8'h80, 8'h00, IntTag, 2, 8'h33, 8'h44, 1, 0, 0,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 2, 8'h11, 8'h22, IntTag, 1, 8'hff, 8'h00, 1, 0, 0,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 2, 8'h00, 8'h7f, IntTag, 1, 8'h01, 8'h00, 1, 0, 0,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 1, 8'h01, 8'h00, IntTag, 3, 8'h00, 8'h00, 0, 0, 0,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 2, 8'h00, 8'h80, IntTag, 1, 8'h01, 8'h00, 0, 0, 0,
                WANT_PASS));
    add_row(row(SeqTag, IntTag, 1, 8'h00, 8'h00, IntTag, 2, 8'h05, 8'h00, 0, 0, 0,
                WANT_MODEL));
    add_row(row(SeqTag, IntTag, 0, 8'h00, 8'h00, IntTag, 5, 8'h01, 8'h02, 1, 0, 0,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 2, 8'h11, 8'h22, IntTag, 34, 8'h01, 8'h02, 0, 0, 0,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 34, 8'h11, 8'h22, IntTag, 1, 8'h01, 8'h02, 0, 0, 0,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 3, 8'h11, 8'h22, IntTag, 4, 8'h01, 8'h02, 0, -1, 0,
                WANT_MODEL));
    add_row(row(SeqTag, IntTag, 3, 8'h11, 8'h22, IntTag, 4, 8'h01, 8'h02, 1, 1, 0,
                WANT_MODEL));
    add_row(row(SeqTag, IntTag, 3, 8'h11, 8'h22, IntTag, 4, 8'h01, 8'h02, 0, 2, 0,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 3, 8'h11, 8'h22, IntTag, 4, 8'h01, 8'h02, 0, 0, 2,
                WANT_FAIL));
    add_row(row(SeqTag, IntTag, 3, 8'h11, 8'h22, IntTag, 4, 8'h01, 8'h02, 0, 0, 1,
                WANT_MODEL));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      form_sig(dir_rows[i]);
      bytes_sent += sig_bytes.size();
      send_sig(dir_rows[i].want);
    end

    // mostly well-formed signatures, some broken, some noise
    while (bytes_sent < 1100) begin
      if (rand_sigs % 8 == 0) quiet = ($urandom_range(0, 3) == 0);
      make_random_sig();
      bytes_sent += sig_bytes.size();
      rand_sigs++;
      send_sig(WANT_MODEL);
    end
    in_valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
